[design/rsi_pkg.sv]
// shared types and widths for the ray versus sphere intersection pipeline
package rsi_pkg;

  localparam int unsigned RootW = 52;   // root bits, disc < 2^104
  localparam int unsigned RemW  = 104;  // square root remainder width
  localparam int unsigned DiscW = 106;  // signed discriminant width
  localparam int unsigned BW    = 53;   // signed dot product width, Q.32

  localparam logic [2:0] CfgCenterX = 3'd0;
  localparam logic [2:0] CfgCenterY = 3'd1;
  localparam logic [2:0] CfgCenterZ = 3'd2;
  localparam logic [2:0] CfgRadius  = 3'd3;

  // per-ray data that rides alongside the root computation
  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][17:0] dir;
    logic [BW-1:0]    b;
    logic             hit;
  } side_t;

endpackage

[design/rsi_front.sv]
// front stages: offset, dot products, squares and the discriminant
module rsi_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][31:0]              in_org,
  input  logic [2:0][17:0]              in_dir,
  input  logic [2:0][31:0]              center,
  input  logic [30:0]                   radius,
  output logic                          out_valid,
  output logic [rsi_pkg::RemW-1:0]      out_rem,
  output rsi_pkg::side_t                out_side
);

  logic                 v1, v2, v3, v4;
  rsi_pkg::side_t       s1, s2, s3, s4;
  logic signed [32:0]   d1 [3];
  logic signed [50:0]   p2 [3];
  logic signed [65:0]   sq2 [3];
  logic [61:0]          r2_2, r2_3, r2_4;
  logic [65:0]          c3, c4;
  logic [51:0]          hh4, hl4, ll4;
  logic [51:0]          bmag;
  logic signed [rsi_pkg::DiscW-1:0] disc;

  function automatic logic signed [32:0] in_dir_ext(input logic [17:0] x);
    return 33'($signed(x));
  endfunction

  function automatic logic [rsi_pkg::BW-1:0] BW_sum(input logic signed [50:0] a,
                                                    input logic signed [50:0] b,
                                                    input logic signed [50:0] c);
    logic signed [52:0] s;
    s = 53'(a) + 53'(b) + 53'(c);
    return s;
  endfunction

  assign bmag = s3.b[52] ? 52'(-$signed(s3.b)) : s3.b[51:0];

  always_comb begin
    disc = $signed({54'b0, hh4} << 52) + $signed({54'b0, hl4} << 27)
         + $signed({54'b0, ll4}) + $signed({44'b0, r2_4} << 32)
         - $signed({40'b0, c4} << 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // offset from the sphere center
      s1.org <= in_org;
      s1.dir <= in_dir;
      s1.b   <= '0;
      s1.hit <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        d1[i] <= $signed({in_org[i][31], in_org[i]}) - $signed({center[i][31], center[i]});
      end
      // products
      s2 <= s1;
      for (int i = 0; i < 3; i++) begin
        p2[i]  <= $signed(in_dir_ext(s1.dir[i])) * d1[i];
        sq2[i] <= d1[i] * d1[i];
      end
      r2_2 <= radius * radius;
      // sums
      s3.org <= s2.org;
      s3.dir <= s2.dir;
      s3.hit <= s2.hit;
      s3.b   <= BW_sum(p2[0], p2[1], p2[2]);
      c3   <= 66'(sq2[0][64:0]) + 66'(sq2[1][64:0]) + 66'(sq2[2][64:0]);
      r2_3 <= r2_2;
      // square of b in three partial products
      s4   <= s3;
      hh4  <= bmag[51:26] * bmag[51:26];
      hl4  <= bmag[51:26] * bmag[25:0];
      ll4  <= bmag[25:0] * bmag[25:0];
      c4   <= c3;
      r2_4 <= r2_3;
      // discriminant sign decides the hit
      out_side.org <= s4.org;
      out_side.dir <= s4.dir;
      out_side.b   <= s4.b;
      out_side.hit <= ~disc[rsi_pkg::DiscW-1];
      out_rem      <= disc[rsi_pkg::DiscW-1] ? '0 : disc[rsi_pkg::RemW-1:0];
    end
  end

endmodule

[design/rsi_sqrt_cell.sv]
// one cell of the square root chain, settles one root bit per stage
module rsi_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [rsi_pkg::RemW-1:0]      in_rem,
  input  logic [rsi_pkg::RootW-1:0]     in_q,
  input  rsi_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [rsi_pkg::RemW-1:0]      out_rem,
  output logic [rsi_pkg::RootW-1:0]     out_q,
  output rsi_pkg::side_t                out_side
);

  logic [rsi_pkg::RemW-1:0] trial;
  logic                     take;

  // (2q + 2^k) * 2^k, q holds only bits above k
  assign trial = (rsi_pkg::RemW'(in_q) << (K + 1)) | (rsi_pkg::RemW'(1) << (2 * K));
  assign take  = in_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? in_rem - trial : in_rem;
      out_q    <= take ? (in_q | (rsi_pkg::RootW'(1) << K)) : in_q;
      out_side <= in_side;
    end
  end

endmodule

[design/rsi_back.sv]
// back stages: distance from the root, then the saturated hit point
module rsi_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [rsi_pkg::RootW-1:0]     in_q,
  input  rsi_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [31:0]                   out_dist,
  output logic [2:0][31:0]              out_point
);

  logic                 v1, v2;
  rsi_pkg::side_t       s1, s2;
  logic signed [31:0]   dist1, dist2;
  logic signed [49:0]   m2 [3];
  logic signed [53:0]   t;
  logic signed [37:0]   tf;
  logic signed [31:0]   dist_sat;
  logic signed [34:0]   psum [3];

  always_comb begin
    t  = -$signed({in_side.b[52], in_side.b}) - $signed({2'b0, in_q});
    tf = 38'(t >>> 16);
    if (tf > 38'sd2147483647) begin
      dist_sat = 32'sh7fffffff;
    end else if (tf < -38'sd2147483648) begin
      dist_sat = 32'sh80000000;
    end else begin
      dist_sat = tf[31:0];
    end
    if (!in_side.hit) begin
      dist_sat = '0;
    end
    for (int i = 0; i < 3; i++) begin
      psum[i] = 35'($signed(s2.org[i])) + 35'(m2[i] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= in_side;
      dist1 <= dist_sat;
      s2    <= s1;
      dist2 <= dist1;
      for (int i = 0; i < 3; i++) begin
        m2[i] <= $signed(s1.dir[i]) * dist1;
      end
      out_hit  <= s2.hit;
      out_dist <= dist2;
      for (int i = 0; i < 3; i++) begin
        if (psum[i] > 35'sd2147483647) begin
          out_point[i] <= 32'h7fffffff;
        end else if (psum[i] < -35'sd2147483648) begin
          out_point[i] <= 32'h80000000;
        end else begin
          out_point[i] <= psum[i][31:0];
        end
      end
    end
  end

endmodule

[design/ray_sphere_intersect.sv]
// Ray versus sphere intersection in Q16.16. One ray enters per cycle while the pipeline is
// not held: 5 front stages form the offset, dot product, squares and discriminant, a row of
// 52 square root cells settles one root bit each, and 3 back stages form the distance and
// the saturated point. The whole pipeline holds while a result waits at the output, so
// throughput is one ray per cycle whenever m_tready stays high.
module ray_sphere_intersect (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [151:0]  s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // distance, point_x, point_y, point_z
  output logic [0:0]    m_tuser,   // hit
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int unsigned N = rsi_pkg::RootW;

  logic [2:0][31:0]  center;
  logic [30:0]       radius;
  logic              en;
  logic [2:0][31:0]  org;
  logic [2:0][17:0]  dir;
  logic              cv [N+1];
  logic [rsi_pkg::RemW-1:0]  crem [N+1];
  logic [rsi_pkg::RootW-1:0] cq [N+1];
  rsi_pkg::side_t    cs [N+1];
  logic [31:0]       res_dist;
  logic [2:0][31:0]  point;
  logic              hit;

  assign en        = m_tready | ~m_tvalid;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      radius <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        rsi_pkg::CfgCenterX: center[0] <= cfg_data;
        rsi_pkg::CfgCenterY: center[1] <= cfg_data;
        rsi_pkg::CfgCenterZ: center[2] <= cfg_data;
        rsi_pkg::CfgRadius:  radius    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign org[0] = s_tdata[31:0];
  assign org[1] = s_tdata[63:32];
  assign org[2] = s_tdata[95:64];
  assign dir[0] = s_tdata[113:96];
  assign dir[1] = s_tdata[131:114];
  assign dir[2] = s_tdata[149:132];

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_org    (org),
    .in_dir    (dir),
    .center    (center),
    .radius    (radius),
    .out_valid (cv[0]),
    .out_rem   (crem[0]),
    .out_side  (cs[0])
  );

  assign cq[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    rsi_sqrt_cell #(.K(N - 1 - g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[g]),
      .in_rem    (crem[g]),
      .in_q      (cq[g]),
      .in_side   (cs[g]),
      .out_valid (cv[g+1]),
      .out_rem   (crem[g+1]),
      .out_q     (cq[g+1]),
      .out_side  (cs[g+1])
    );
  end

  rsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv[N]),
    .in_q      (cq[N]),
    .in_side   (cs[N]),
    .out_valid (m_tvalid),
    .out_hit   (hit),
    .out_dist  (res_dist),
    .out_point (point)
  );

  assign m_tdata = {point[2], point[1], point[0], res_dist};
  assign m_tuser = hit;

  // final remainder of the last cell is not needed
  logic unused_rem;
  assign unused_rem = ^crem[N];

endmodule

[tb/sv/ray_sphere_intersect_tb.sv]
// self-checking testbench for the ray versus sphere intersection pipeline
`timescale 1ns / 100ps

module ray_sphere_intersect_tb;

  localparam logic [2:0] CfgUnusedLo = 3'd4;
  localparam logic [2:0] CfgUnusedHi = 3'd7;
  localparam int PhaseRays = 170;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [17:0] dir [3];
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] distance;
    logic signed [31:0] pt [3];
  } shot_t;

  typedef struct {
    ray_t  r;
    bit    known;
    shot_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // predictor copy of the sphere registers
  logic signed [31:0] ctr [3];
  logic [30:0]        rad;

  shot_t pending_shots[$];
  int    fails = 0;
  int    send_idle = 0;
  int    recv_stall = 0;
  bit    hold_req = 0;
  int    hold_left = 0;
  row_t  rows[$];
  string axis_name [3] = '{"x", "y", "z"};

  ray_sphere_intersect dut (.*);

  always #10 clk = ~clk;

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic shot_t trace_ray(ray_t r);
    shot_t       o;
    longint      d, b, t, dclamp;
    logic [63:0] m, root, cand;
    logic [129:0] c, lhs, disc;
    b = 0;
    c = '0;
    for (int i = 0; i < 3; i++) begin
      d = longint'(r.org[i]) - longint'(ctr[i]);
      b += longint'(r.dir[i]) * d;
      m = (d < 0) ? 64'(-d) : 64'(d);
      c += 130'(m) * 130'(m);
    end
    c = c << 32;
    m = (b < 0) ? 64'(-b) : 64'(b);
    lhs = 130'(m) * 130'(m) + ((130'(rad) * 130'(rad)) << 32);
    if (lhs < c) begin
      o.hit = 1'b0;
      o.distance = '0;
      for (int i = 0; i < 3; i++) o.pt[i] = r.org[i];
      return o;
    end
    disc = lhs - c;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if (130'(cand) * 130'(cand) <= disc) root = cand;
    end
    t = -b - longint'(root);
    dclamp = longint'(clamp32(t >>> 16));
    o.hit = 1'b1;
    o.distance = dclamp[31:0];
    for (int i = 0; i < 3; i++)
      o.pt[i] = clamp32(longint'(r.org[i]) + ((longint'(r.dir[i]) * dclamp) >>> 16));
    return o;
  endfunction

  function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
    r.dir[0] = dx[17:0]; r.dir[1] = dy[17:0]; r.dir[2] = dz[17:0];
    return r;
  endfunction

  function automatic shot_t mk_shot(bit h, int dval, int px, int py, int pz);
    shot_t s;
    s.hit = h; s.distance = dval;
    s.pt[0] = px; s.pt[1] = py; s.pt[2] = pz;
    return s;
  endfunction

  function automatic void add_row(ray_t r, bit known, shot_t want);
    row_t w;
    w.r = r; w.known = known; w.want = want;
    rows.push_back(w);
  endfunction

  // rays biased toward the sphere so that most of them hit
  function automatic ray_t aimed_ray();
    ray_t r;
    int   span;
    span = (rad > 31'd16) ? int'(rad) : 65536;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = ctr[i] + $signed($urandom_range(2 * span)) - span;
      r.dir[i] = 18'($signed($urandom_range(131072)) - 65536);
    end
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = $urandom;
      r.dir[i] = 18'($urandom);
    end
    return r;
  endfunction

  task automatic send_ray(ray_t r, bit known, shot_t want);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_shots.push_back(known ? want : trace_ray(r));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_shots.size() > 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      rsi_pkg::CfgCenterX: ctr[0] = val;
      rsi_pkg::CfgCenterY: ctr[1] = val;
      rsi_pkg::CfgCenterZ: ctr[2] = val;
      rsi_pkg::CfgRadius:  rad = val[30:0];
      default: ;
    endcase
  endtask

  // receiver: check each result transfer, then pick next ready
  always @(posedge clk) begin
    shot_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_shots.size() == 0) begin
        $error("result with nothing expected");
        fails++;
      end else begin
        want = pending_shots.pop_front();
        if (m_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_tuser[0]);
          fails++;
        end
        if (m_tdata[31:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, $signed(m_tdata[31:0]));
          fails++;
        end
        for (int i = 0; i < 3; i++)
          if (m_tdata[32*(i+1) +: 32] !== want.pt[i]) begin
            $error("point_%s: expected %0d, got %0d", axis_name[i], want.pt[i],
                   $signed(m_tdata[32*(i+1) +: 32]));
            fails++;
          end
      end
    end
    if (hold_req) begin
      hold_left = 300;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    ctr[0] = 0; ctr[1] = 0; ctr[2] = 0;
    rad = 31'd65536;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unit sphere at the origin after reset
    add_row(mk_ray(0, 0, -131072, 0, 0, 65536), 1, mk_shot(1, 65536, 0, 0, -65536));
    add_row(mk_ray(0, 196608, -131072, 0, 0, 65536), 1,
            mk_shot(0, 0, 0, 196608, -131072));
    // tangent ray
    add_row(mk_ray(0, 65536, -131072, 0, 0, 65536), 1, mk_shot(1, 131072, 0, 65536, 0));
    // origin inside, nearer root behind
    add_row(mk_ray(0, 0, 0, 0, 0, 65536), 1, mk_shot(1, -65536, 0, 0, -65536));
    add_row(mk_ray(0, 0, 0, -65536, 0, 0), 1, mk_shot(1, -65536, 65536, 0, 0));
    add_row(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 131071, 131071, 131071), 0,
            mk_shot(0, 0, 0, 0, 0));
    add_row(mk_ray(32'h80000000, 32'h80000000, 32'h80000000, -131072, -131072, -131072),
            0, mk_shot(0, 0, 0, 0, 0));
    add_row(mk_ray(32'h7fffffff, 32'h80000000, 0, 65536, -65536, 0), 0,
            mk_shot(0, 0, 0, 0, 0));
    add_row(mk_ray(32'h80000000, 0, 32'h7fffffff, -131072, 131071, 1), 0,
            mk_shot(0, 0, 0, 0, 0));
    add_row(mk_ray(-196608, 0, 0, 65536, 0, 0), 0, mk_shot(0, 0, 0, 0, 0));
    add_row(mk_ray(0, 0, -131072, 0, 0, 0), 0, mk_shot(0, 0, 0, 0, 0));
    add_row(mk_ray(0, 0, 0, 0, 0, 0), 0, mk_shot(0, 0, 0, 0, 0));
    add_row(mk_ray(12345, -54321, 99999, 46341, 46341, 0), 0, mk_shot(0, 0, 0, 0, 0));
    foreach (rows[k]) send_ray(rows[k].r, rows[k].known, rows[k].want);
    drain();

    // huge sphere so the saturation paths show up
    cfg_write(rsi_pkg::CfgRadius, 32'h7fffffff);
    foreach (rows[k]) send_ray(rows[k].r, 0, rows[k].want);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          cfg_write(rsi_pkg::CfgCenterX, 32'h7fffffff);
          cfg_write(rsi_pkg::CfgCenterY, 32'h7fffffff);
          cfg_write(rsi_pkg::CfgCenterZ, 32'h7fffffff);
          cfg_write(rsi_pkg::CfgRadius, 32'h7fffffff);
        end
        2: begin
          cfg_write(rsi_pkg::CfgCenterX, 32'h80000000);
          cfg_write(rsi_pkg::CfgCenterY, 32'h80000000);
          cfg_write(rsi_pkg::CfgCenterZ, 32'h80000000);
          cfg_write(rsi_pkg::CfgRadius, 32'h0);
        end
        default: begin
          cfg_write(rsi_pkg::CfgCenterX, $urandom_range(32'h00400000) - 32'h00200000);
          cfg_write(rsi_pkg::CfgCenterY, $urandom);
          cfg_write(rsi_pkg::CfgCenterZ, $urandom_range(32'h00400000) - 32'h00200000);
          cfg_write(rsi_pkg::CfgRadius,
                    (ph == 0) ? $urandom : $urandom_range(32'h00080000, 1));
        end
      endcase
      // writes to unused indexes must leave the registers alone
      cfg_write(3'($urandom_range(CfgUnusedHi, CfgUnusedLo)), $urandom);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      for (int n = 0; n < PhaseRays; n++) begin
        if (ph == 0 && n == 20) hold_req = 1;
        if ($urandom_range(3) == 0) send_ray(noise_ray(), 0, rows[0].want);
        else send_ray(aimed_ray(), 0, rows[0].want);
      end
      drain();
    end

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
